// File: rtl/nfha_pkg.sv
// Shared types and constants for the next-fit heap allocator.
// Used by the remainder unit, datapath, controller and top level.
package nfha_pkg;

   localparam int HEAP_BYTES    = 65536;
   localparam int HEADER_BYTES  = 32;
   localparam int GRANULE_BYTES = 16;
   localparam int SLOTS         = HEAP_BYTES / GRANULE_BYTES;
   localparam int IDX_W         = $clog2(SLOTS);
   localparam int GRAN_SH       = $clog2(GRANULE_BYTES);
   localparam int SIZE_W        = 16;
   localparam int CAP_W         = 17;
   localparam int ALIGN_W       = 14;
   localparam int END_W         = 18;
   localparam int DIV_STEPS     = 17;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int MIN_CAP       = HEADER_BYTES + GRANULE_BYTES;

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_NOP   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_NO_FIT  = 2'd2
   } rsp_code_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_FORMAT, OP_MOD_SIZE, OP_SET_S, OP_READ_FIT,
      OP_MOD_FIT, OP_SPLIT_PAD, OP_ADVANCE, OP_SPLIT_TRIM, OP_SPLIT1,
      OP_SPLIT2, OP_SPLIT3, OP_MARK_USED, OP_READ_NF, OP_NF_ADV,
      OP_CURSOR_SET, OP_CURSOR_CLR, OP_FR_INIT, OP_READ_S, OP_FR_ADV,
      OP_FR_CLR, OP_READ_NEXT, OP_READ_PREV, OP_MERGE_INIT_S,
      OP_MERGE_INIT_P, OP_READ_MB, OP_MERGE_NX, OP_MERGE_WR, OP_MERGE_PREV
   } op_type;

   typedef struct packed {
      op_type       op;
      logic         cap_load;
      logic         emit;
      rsp_code_type code;
      logic         with_offset;
   } cmd_type;

   typedef struct packed {
      logic cvalid;
      logic div_busy;
      logic rem_zero;
      logic pad_fits;
      logic fit_ok;
      logic adv_wrap;
      logic fsz_big;
      logic q_used;
      logic q_has_next;
      logic nf_wrap;
      logic fo_bad;
      logic s_lt;
      logic s_eq;
      logic s_zero;
   } sts_type;

endpackage

// File: rtl/nfha_rem_unit.sv
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
// Depends on nfha_pkg.
module nfha_rem_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [nfha_pkg::CAP_W-1:0]    dividend,
   input  logic [nfha_pkg::ALIGN_W-1:0]  divisor,
   output logic                          busy,
   output logic [nfha_pkg::ALIGN_W-1:0]  rem
);
   import nfha_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [CAP_W-1:0]     x_ff;
   logic [ALIGN_W-1:0]   d_ff;
   logic [ALIGN_W-1:0]   rem_ff;
   logic [ALIGN_W:0]     trial;

   assign trial = {rem_ff, x_ff[CAP_W-1]};
   assign busy  = (cnt_ff != '0);
   assign rem   = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= dividend;
         d_ff   <= divisor;
         rem_ff <= '0;
      end else if (busy) begin
         x_ff <= {x_ff[CAP_W-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            rem_ff <= ALIGN_W'(trial - {1'b0, d_ff});
         end else begin
            rem_ff <= ALIGN_W'(trial);
         end
      end
   end

endmodule

// File: rtl/nfha_datapath.sv
// Datapath: block header memories, request registers, cursor and result.
// Depends on nfha_pkg and nfha_rem_unit; driven by commands from nfha_ctrl.
module nfha_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  nfha_pkg::cmd_type    cmd,
   output nfha_pkg::sts_type    sts,
   input  logic [15:0]          req_size,
   input  logic [12:0]          req_alignment,
   input  logic [15:0]          req_free_offset,
   input  logic [16:0]          csr_heap_bytes,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_data_offset
);
   import nfha_pkg::*;

   // header stores
   logic [SIZE_W-1:0] size_mem [SLOTS];
   logic              used_mem [SLOTS];
   logic [IDX_W-1:0]  prev_mem [SLOTS];

   logic [CAP_W-1:0]   cap_ff;
   logic [IDX_W-1:0]   cursor_ff;
   logic               cvalid_ff;
   logic [ALIGN_W-1:0] a_ff;
   logic [CAP_W-1:0]   s_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [SIZE_W-1:0]  fo_ff;
   logic [IDX_W-1:0]   fit_ff;
   logic [SIZE_W-1:0]  fsz_ff;
   logic [IDX_W-1:0]   nf_ff;
   logic [IDX_W-1:0]   sidx_ff;
   logic [IDX_W-1:0]   mb_ff;
   logic [IDX_W-1:0]   mnx_ff;
   logic [SIZE_W-1:0]  msz_ff;
   logic [IDX_W-1:0]   sp_b_ff;
   logic [CAP_W-1:0]   sp_keep_ff;
   logic [SIZE_W-1:0]  sp_bsz_ff;
   logic [SIZE_W-1:0]  q_size_ff;
   logic               q_used_ff;
   logic [IDX_W-1:0]   q_prev_ff;
   logic [IDX_W-1:0]   qidx_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [15:0]        rsp_offset_ff;

   // memory port controls
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              we_size, we_used, we_prev;
   logic [IDX_W-1:0]  wr_addr;
   logic [SIZE_W-1:0] wd_size;
   logic              wd_used;
   logic [IDX_W-1:0]  wd_prev;

   // remainder unit
   logic               div_start;
   logic [CAP_W-1:0]   div_x;
   logic               div_busy;
   logic [ALIGN_W-1:0] rem;

   // derived values
   logic [12:0]        a0;
   logic [ALIGN_W-1:0] a_up;
   logic [END_W-1:0]   q_end;
   logic               q_has_next;
   logic [IDX_W-1:0]   q_next;
   logic [IDX_W-1:0]   adv_n;
   logic [ALIGN_W:0]   r32, r2a, r2;
   logic [ALIGN_W-1:0] pad;
   logic [CAP_W-1:0]   s_new;
   logic [IDX_W-1:0]   nb;
   logic [SIZE_W-1:0]  nsz;
   logic [END_W-1:0]   nb_end;
   logic [SIZE_W-1:0]  t_off;
   logic [SIZE_W-1:0]  s_addr;
   logic [SIZE_W-1:0]  newsz;
   logic [END_W-1:0]   m_end;
   logic [END_W-1:0]   cap_round;
   logic [CAP_W-1:0]   cap_new;

   nfha_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_x),
      .divisor  (a_ff),
      .busy     (div_busy),
      .rem      (rem)
   );

   always_comb begin
      a0   = (req_alignment == '0) ? 13'd1 : req_alignment;
      a_up = (ALIGN_W'(a0) + ALIGN_W'(GRANULE_BYTES - 1)) & ~ALIGN_W'(GRANULE_BYTES - 1);

      q_end      = END_W'({qidx_ff, GRAN_SH'(0)}) + END_W'(HEADER_BYTES) + END_W'(q_size_ff);
      q_has_next = q_end < END_W'(cap_ff);
      q_next     = q_end[IDX_W+GRAN_SH-1:GRAN_SH];
      adv_n      = q_has_next ? q_next : '0;

      // pad = A - ((addr + 2 * header) mod A), from r = (addr + header) mod A
      r32 = (ALIGN_W+1)'(rem) + (ALIGN_W+1)'(HEADER_BYTES);
      r2a = (r32 >= (ALIGN_W+1)'(a_ff)) ? r32 - (ALIGN_W+1)'(a_ff) : r32;
      r2  = (r2a >= (ALIGN_W+1)'(a_ff)) ? r2a - (ALIGN_W+1)'(a_ff) : r2a;
      pad = ALIGN_W'((ALIGN_W+1)'(a_ff) - r2);

      s_new = CAP_W'(size_ff) + ((rem == '0) ? '0 : CAP_W'(a_ff - rem));

      nb     = sp_b_ff + IDX_W'((END_W'(HEADER_BYTES) + END_W'(sp_keep_ff)) >> GRAN_SH);
      nsz    = SIZE_W'(END_W'(sp_bsz_ff) - END_W'(sp_keep_ff) - END_W'(HEADER_BYTES));
      nb_end = END_W'({nb, GRAN_SH'(0)}) + END_W'(HEADER_BYTES) + END_W'(nsz);

      t_off  = fo_ff - SIZE_W'(HEADER_BYTES);
      s_addr = {sidx_ff, GRAN_SH'(0)};

      newsz = msz_ff + q_size_ff + SIZE_W'(HEADER_BYTES);
      m_end = END_W'({mb_ff, GRAN_SH'(0)}) + END_W'(HEADER_BYTES) + END_W'(msz_ff);

      cap_round = (END_W'(csr_heap_bytes) + END_W'(GRANULE_BYTES - 1))
                  & ~END_W'(GRANULE_BYTES - 1);
      if (cap_round < END_W'(MIN_CAP)) begin
         cap_new = CAP_W'(MIN_CAP);
      end else if (cap_round > END_W'(HEAP_BYTES)) begin
         cap_new = CAP_W'(HEAP_BYTES);
      end else begin
         cap_new = CAP_W'(cap_round);
      end
   end

   always_comb begin
      sts.cvalid     = cvalid_ff;
      sts.div_busy   = div_busy;
      sts.rem_zero   = (rem == '0);
      sts.pad_fits   = END_W'(fsz_ff) >= END_W'(pad) + END_W'(HEADER_BYTES) + END_W'(s_ff);
      sts.fit_ok     = !q_used_ff && (CAP_W'(q_size_ff) >= s_ff);
      sts.adv_wrap   = (adv_n == cursor_ff);
      sts.fsz_big    = END_W'(fsz_ff) > END_W'(s_ff) + END_W'(HEADER_BYTES);
      sts.q_used     = q_used_ff;
      sts.q_has_next = q_has_next;
      sts.nf_wrap    = (adv_n == fit_ff);
      sts.fo_bad     = (fo_ff < SIZE_W'(HEADER_BYTES)) || (t_off[GRAN_SH-1:0] != '0)
                       || (CAP_W'(t_off) >= cap_ff);
      sts.s_lt       = s_addr < t_off;
      sts.s_eq       = s_addr == t_off;
      sts.s_zero     = (sidx_ff == '0);
   end

   // memory port and remainder unit control
   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = '0;
      we_size   = 1'b0;
      we_used   = 1'b0;
      we_prev   = 1'b0;
      wr_addr   = '0;
      wd_size   = '0;
      wd_used   = 1'b0;
      wd_prev   = '0;
      div_start = 1'b0;
      div_x     = '0;
      case (cmd.op)
         OP_FORMAT: begin
            we_size = 1'b1;
            we_used = 1'b1;
            we_prev = 1'b1;
            wd_size = SIZE_W'(cap_ff - CAP_W'(HEADER_BYTES));
         end
         OP_MOD_SIZE: begin
            div_start = 1'b1;
            div_x     = CAP_W'(size_ff);
         end
         OP_READ_FIT: begin
            rd_en   = 1'b1;
            rd_addr = fit_ff;
         end
         OP_MOD_FIT: begin
            div_start = 1'b1;
            div_x     = CAP_W'({fit_ff, GRAN_SH'(0)}) + CAP_W'(HEADER_BYTES);
         end
         OP_SPLIT1: begin
            we_size = 1'b1;
            we_used = 1'b1;
            we_prev = 1'b1;
            wr_addr = nb;
            wd_size = nsz;
            wd_prev = sp_b_ff;
         end
         OP_SPLIT2: begin
            we_size = 1'b1;
            wr_addr = sp_b_ff;
            wd_size = SIZE_W'(sp_keep_ff);
         end
         OP_SPLIT3: begin
            we_prev = nb_end < END_W'(cap_ff);
            wr_addr = nb_end[IDX_W+GRAN_SH-1:GRAN_SH];
            wd_prev = nb;
         end
         OP_MARK_USED: begin
            we_used = 1'b1;
            wr_addr = fit_ff;
            wd_used = 1'b1;
         end
         OP_READ_NF: begin
            rd_en   = 1'b1;
            rd_addr = nf_ff;
         end
         OP_NF_ADV: begin
            rd_en   = 1'b1;
            rd_addr = adv_n;
         end
         OP_READ_S: begin
            rd_en   = 1'b1;
            rd_addr = sidx_ff;
         end
         OP_FR_CLR: begin
            we_used = 1'b1;
            wr_addr = sidx_ff;
         end
         OP_READ_NEXT, OP_MERGE_NX: begin
            rd_en   = 1'b1;
            rd_addr = q_next;
         end
         OP_READ_PREV: begin
            rd_en   = 1'b1;
            rd_addr = q_prev_ff;
         end
         OP_READ_MB: begin
            rd_en   = 1'b1;
            rd_addr = mb_ff;
         end
         OP_MERGE_WR: begin
            we_size = 1'b1;
            wr_addr = mb_ff;
            wd_size = newsz;
         end
         OP_MERGE_PREV: begin
            we_prev = m_end < END_W'(cap_ff);
            wr_addr = m_end[IDX_W+GRAN_SH-1:GRAN_SH];
            wd_prev = mb_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_size) size_mem[wr_addr] <= wd_size;
      if (we_used) used_mem[wr_addr] <= wd_used;
      if (we_prev) prev_mem[wr_addr] <= wd_prev;
      if (rd_en) begin
         q_size_ff <= size_mem[rd_addr];
         q_used_ff <= used_mem[rd_addr];
         q_prev_ff <= prev_mem[rd_addr];
         qidx_ff   <= rd_addr;
      end
   end

   // control state: capacity, cursor, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_W'(HEAP_BYTES);
         cursor_ff    <= '0;
         cvalid_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
         if (cmd.cap_load) cap_ff <= cap_new;
         case (cmd.op)
            OP_FORMAT: begin
               cursor_ff <= '0;
               cvalid_ff <= 1'b1;
            end
            OP_CURSOR_SET: begin
               cursor_ff <= nf_ff;
               cvalid_ff <= 1'b1;
            end
            OP_CURSOR_CLR: begin
               cursor_ff <= '0;
               cvalid_ff <= 1'b0;
            end
            OP_FR_CLR: begin
               if (!cvalid_ff) begin
                  cursor_ff <= sidx_ff;
                  cvalid_ff <= 1'b1;
               end
            end
            OP_MERGE_WR: begin
               // the absorbed block may have held the cursor
               if (cvalid_ff && cursor_ff == mnx_ff) cursor_ff <= mb_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.code;
         rsp_offset_ff <= cmd.with_offset
                          ? ({fit_ff, GRAN_SH'(0)} + SIZE_W'(HEADER_BYTES)) : '0;
      end
      case (cmd.op)
         OP_ACCEPT: begin
            size_ff <= req_size;
            fo_ff   <= req_free_offset;
            a_ff    <= a_up;
         end
         OP_SET_S: begin
            s_ff   <= s_new;
            fit_ff <= cursor_ff;
         end
         OP_MOD_FIT: fsz_ff <= q_size_ff;
         OP_SPLIT_PAD: begin
            sp_b_ff    <= fit_ff;
            sp_keep_ff <= CAP_W'(pad);
            sp_bsz_ff  <= fsz_ff;
            fit_ff     <= fit_ff + IDX_W'((END_W'(HEADER_BYTES) + END_W'(pad)) >> GRAN_SH);
            fsz_ff     <= SIZE_W'(END_W'(fsz_ff) - END_W'(pad) - END_W'(HEADER_BYTES));
         end
         OP_ADVANCE: fit_ff <= adv_n;
         OP_SPLIT_TRIM: begin
            sp_b_ff    <= fit_ff;
            sp_keep_ff <= s_ff;
            sp_bsz_ff  <= fsz_ff;
         end
         OP_MARK_USED: nf_ff <= fit_ff;
         OP_NF_ADV: nf_ff <= adv_n;
         OP_FR_INIT: sidx_ff <= '0;
         OP_FR_ADV: sidx_ff <= q_next;
         OP_MERGE_INIT_S: mb_ff <= sidx_ff;
         OP_MERGE_INIT_P: mb_ff <= qidx_ff;
         OP_MERGE_NX: begin
            mnx_ff <= q_next;
            msz_ff <= q_size_ff;
         end
         OP_MERGE_WR: msz_ff <= newsz;
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_offset = rsp_offset_ff;

endmodule

// File: rtl/nfha_ctrl.sv
// Controller: sequences allocate, free and flush requests over the datapath.
// Depends on nfha_pkg; talks to nfha_datapath through cmd_type and sts_type.
module nfha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_type,
   input  logic                csr_valid,
   input  nfha_pkg::sts_type   sts,
   output logic                busy,
   output logic                csr_ready,
   output nfha_pkg::cmd_type   cmd
);
   import nfha_pkg::*;

   typedef enum logic [26:0] {
      S_FMT     = 27'd1 << 0,
      S_IDLE    = 27'd1 << 1,
      S_FLUSH   = 27'd1 << 2,
      S_DONE    = 27'd1 << 3,
      S_A_CHK   = 27'd1 << 4,
      S_A_MODW  = 27'd1 << 5,
      S_A_RD    = 27'd1 << 6,
      S_A_FIT   = 27'd1 << 7,
      S_A_MODF  = 27'd1 << 8,
      S_FOUND   = 27'd1 << 9,
      S_SP1     = 27'd1 << 10,
      S_SP2     = 27'd1 << 11,
      S_SP3     = 27'd1 << 12,
      S_MARK    = 27'd1 << 13,
      S_NF_RD   = 27'd1 << 14,
      S_NF_STEP = 27'd1 << 15,
      S_F_CHK   = 27'd1 << 16,
      S_F_WALK  = 27'd1 << 17,
      S_F_NX    = 27'd1 << 18,
      S_F_CLR   = 27'd1 << 19,
      S_F_RS    = 27'd1 << 20,
      S_F_QS    = 27'd1 << 21,
      S_F_QN    = 27'd1 << 22,
      S_F_PREV  = 27'd1 << 23,
      S_F_QP    = 27'd1 << 24,
      S_F_QPP   = 27'd1 << 25,
      S_M_RB    = 27'd1 << 26
   } state_type;

   typedef enum logic [2:0] {
      M_QB = 3'b001,
      M_QN = 3'b010,
      M_PR = 3'b100
   } merge_type;

   state_type state_ff, state_in;
   merge_type mstep_ff, mstep_in;
   logic      in_merge_ff, in_merge_in;
   logic      ret_trim_ff, ret_trim_in;
   logic      ret_prev_ff, ret_prev_in;
   logic      first_ff, first_in;

   assign csr_ready = (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE) || csr_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_FMT;
         mstep_ff    <= M_QB;
         in_merge_ff <= 1'b0;
         ret_trim_ff <= 1'b0;
         ret_prev_ff <= 1'b0;
         first_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mstep_ff    <= mstep_in;
         in_merge_ff <= in_merge_in;
         ret_trim_ff <= ret_trim_in;
         ret_prev_ff <= ret_prev_in;
         first_ff    <= first_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      mstep_in        = mstep_ff;
      in_merge_in     = in_merge_ff;
      ret_trim_in     = ret_trim_ff;
      ret_prev_in     = ret_prev_ff;
      first_in        = first_ff;
      cmd.op          = OP_NONE;
      cmd.cap_load    = 1'b0;
      cmd.emit        = 1'b0;
      cmd.code        = ST_OK;
      cmd.with_offset = 1'b0;

      if (in_merge_ff) begin
         // merge the block in mb with its successor, then return
         unique case (mstep_ff)
            M_QB: begin
               if (sts.q_has_next) begin
                  cmd.op   = OP_MERGE_NX;
                  mstep_in = M_QN;
               end else begin
                  in_merge_in = 1'b0;
                  state_in    = ret_prev_ff ? S_DONE : S_F_PREV;
               end
            end
            M_QN: begin
               cmd.op   = OP_MERGE_WR;
               mstep_in = M_PR;
            end
            M_PR: begin
               cmd.op      = OP_MERGE_PREV;
               in_merge_in = 1'b0;
               state_in    = ret_prev_ff ? S_DONE : S_F_PREV;
            end
            default: begin
               in_merge_in = 1'b0;
            end
         endcase
      end else begin
         unique case (state_ff)
            S_FMT: begin
               cmd.op   = OP_FORMAT;
               state_in = S_IDLE;
            end
            S_IDLE: begin
               if (csr_valid) begin
                  cmd.cap_load = 1'b1;
                  state_in     = S_FMT;
               end else if (start) begin
                  cmd.op = OP_ACCEPT;
                  case (req_type)
                     REQ_ALLOC: state_in = S_A_CHK;
                     REQ_FREE:  state_in = S_F_CHK;
                     REQ_FLUSH: state_in = S_FLUSH;
                     default:   state_in = S_DONE;
                  endcase
               end
            end
            S_FLUSH: begin
               cmd.op   = OP_FORMAT;
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
            S_DONE: begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
            S_A_CHK: begin
               if (!sts.cvalid) begin
                  cmd.emit = 1'b1;
                  cmd.code = ST_NO_FREE;
                  state_in = S_IDLE;
               end else begin
                  cmd.op   = OP_MOD_SIZE;
                  state_in = S_A_MODW;
               end
            end
            S_A_MODW: begin
               if (!sts.div_busy) begin
                  cmd.op   = OP_SET_S;
                  state_in = S_A_RD;
               end
            end
            S_A_RD: begin
               cmd.op   = OP_READ_FIT;
               state_in = S_A_FIT;
            end
            S_A_FIT: begin
               if (sts.fit_ok) begin
                  cmd.op   = OP_MOD_FIT;
                  state_in = S_A_MODF;
               end else begin
                  cmd.op = OP_ADVANCE;
                  if (sts.adv_wrap) begin
                     cmd.emit = 1'b1;
                     cmd.code = ST_NO_FIT;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_A_RD;
                  end
               end
            end
            S_A_MODF: begin
               if (!sts.div_busy) begin
                  if (sts.rem_zero) begin
                     state_in = S_FOUND;
                  end else if (sts.pad_fits) begin
                     // carve an aligned block after a free pad
                     cmd.op      = OP_SPLIT_PAD;
                     ret_trim_in = 1'b0;
                     state_in    = S_SP1;
                  end else begin
                     cmd.op = OP_ADVANCE;
                     if (sts.adv_wrap) begin
                        cmd.emit = 1'b1;
                        cmd.code = ST_NO_FIT;
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_A_RD;
                     end
                  end
               end
            end
            S_FOUND: begin
               if (sts.fsz_big) begin
                  cmd.op      = OP_SPLIT_TRIM;
                  ret_trim_in = 1'b1;
                  state_in    = S_SP1;
               end else begin
                  state_in = S_MARK;
               end
            end
            S_SP1: begin
               cmd.op   = OP_SPLIT1;
               state_in = S_SP2;
            end
            S_SP2: begin
               cmd.op   = OP_SPLIT2;
               state_in = S_SP3;
            end
            S_SP3: begin
               cmd.op   = OP_SPLIT3;
               state_in = ret_trim_ff ? S_MARK : S_FOUND;
            end
            S_MARK: begin
               cmd.op   = OP_MARK_USED;
               state_in = S_NF_RD;
            end
            S_NF_RD: begin
               cmd.op   = OP_READ_NF;
               first_in = 1'b1;
               state_in = S_NF_STEP;
            end
            S_NF_STEP: begin
               if (!first_ff && !sts.q_used) begin
                  cmd.op          = OP_CURSOR_SET;
                  cmd.emit        = 1'b1;
                  cmd.with_offset = 1'b1;
                  state_in        = S_IDLE;
               end else if (sts.nf_wrap) begin
                  cmd.op          = OP_CURSOR_CLR;
                  cmd.emit        = 1'b1;
                  cmd.with_offset = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  cmd.op   = OP_NF_ADV;
                  first_in = 1'b0;
               end
            end
            S_F_CHK: begin
               if (sts.fo_bad) begin
                  state_in = S_DONE;
               end else begin
                  cmd.op   = OP_FR_INIT;
                  state_in = S_F_WALK;
               end
            end
            S_F_WALK: begin
               if (sts.s_lt) begin
                  cmd.op   = OP_READ_S;
                  state_in = S_F_NX;
               end else if (sts.s_eq) begin
                  state_in = S_F_CLR;
               end else begin
                  state_in = S_DONE;
               end
            end
            S_F_NX: begin
               if (sts.q_has_next) begin
                  cmd.op   = OP_FR_ADV;
                  state_in = S_F_WALK;
               end else begin
                  state_in = S_DONE;
               end
            end
            S_F_CLR: begin
               cmd.op   = OP_FR_CLR;
               state_in = S_F_RS;
            end
            S_F_RS: begin
               cmd.op   = OP_READ_S;
               state_in = S_F_QS;
            end
            S_F_QS: begin
               if (sts.q_has_next) begin
                  cmd.op   = OP_READ_NEXT;
                  state_in = S_F_QN;
               end else begin
                  state_in = S_F_PREV;
               end
            end
            S_F_QN: begin
               if (!sts.q_used) begin
                  cmd.op      = OP_MERGE_INIT_S;
                  ret_prev_in = 1'b0;
                  state_in    = S_M_RB;
               end else begin
                  state_in = S_F_PREV;
               end
            end
            S_F_PREV: begin
               if (sts.s_zero) begin
                  state_in = S_DONE;
               end else begin
                  cmd.op   = OP_READ_S;
                  state_in = S_F_QP;
               end
            end
            S_F_QP: begin
               cmd.op   = OP_READ_PREV;
               state_in = S_F_QPP;
            end
            S_F_QPP: begin
               if (!sts.q_used) begin
                  cmd.op      = OP_MERGE_INIT_P;
                  ret_prev_in = 1'b1;
                  state_in    = S_M_RB;
               end else begin
                  state_in = S_DONE;
               end
            end
            S_M_RB: begin
               cmd.op      = OP_READ_MB;
               in_merge_in = 1'b1;
               mstep_in    = M_QB;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: rtl/next_fit_heap_allocator_core.sv
// Next-fit heap allocator: a request is taken when start is high and busy is
// low, and exactly one result follows as a one-cycle rsp_valid strobe that the
// receiver cannot hold off. Timing depends on the heap contents: an allocate
// first rounds the size to the alignment in the bit-serial remainder unit;
// each block the search then visits takes a header memory read and a decision,
// plus a pass through the remainder unit for a candidate that is free and large
// enough, and then a split where needed and the next-free cursor walk follow; a
// free walks the block chain from the heap base before merging; a flush
// re-forms the heap and returns its result. After reset, and after every
// heap_bytes write, the heap is re-formed before busy drops.
// Depends on nfha_pkg, nfha_ctrl, nfha_datapath and nfha_rem_unit.
module next_fit_heap_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_size,
   input  logic [12:0] req_alignment,
   input  logic [15:0] req_free_offset,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_data_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_heap_bytes
);
   import nfha_pkg::*;

   cmd_type cmd;
   sts_type sts;

   nfha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .csr_valid (csr_valid),
      .sts       (sts),
      .busy      (busy),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   nfha_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_size        (req_size),
      .req_alignment   (req_alignment),
      .req_free_offset (req_free_offset),
      .csr_heap_bytes  (csr_heap_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_data_offset (rsp_data_offset)
   );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for next_fit_heap_allocator_core: a heap model in the
// scoreboard predicts status and data offset. Depends on nfha_pkg and the core.
module tb_top;
   import nfha_pkg::*;

   class heap_scoreboard;
      int unsigned blk_size[SLOTS];
      bit          blk_used[SLOTS];
      int unsigned blk_prev[SLOTS];
      int unsigned cursor, cap, heap_cfg;
      bit          cursor_ok;
      rsp_code_type want_status[$];
      logic [15:0]  want_offset[$];
      logic [15:0]  live[$];
      int errors, checked, n_ok, n_no_free, n_no_fit;

      function new();
         foreach (blk_size[i]) begin
            blk_size[i] = 0;
            blk_used[i] = 0;
            blk_prev[i] = 0;
         end
         heap_cfg = HEAP_BYTES;
         reform();
      endfunction

      function int unsigned slot(int unsigned s);
         return (s < SLOTS) ? s : SLOTS - 1;
      endfunction

      function bit next_blk(int unsigned s, output int unsigned n);
         int unsigned stop;
         stop = s * GRANULE_BYTES + HEADER_BYTES + blk_size[slot(s)];
         n = 0;
         if (stop >= cap) return 0;
         n = slot(stop / GRANULE_BYTES);
         return 1;
      endfunction

      function void reform();
         int unsigned c;
         c = ((heap_cfg + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
         if (c < MIN_CAP) c = MIN_CAP;
         if (c > HEAP_BYTES) c = HEAP_BYTES;
         cap = c;
         blk_size[0] = cap - HEADER_BYTES;
         blk_used[0] = 0;
         blk_prev[0] = 0;
         cursor = 0;
         cursor_ok = 1;
         live.delete();
      endfunction

      function void configure(int unsigned v);
         heap_cfg = v & 17'h1FFFF;
         reform();
      endfunction

      function void split(int unsigned b, int unsigned keep);
         int unsigned nb, n;
         nb = slot(b + (HEADER_BYTES + keep) / GRANULE_BYTES);
         blk_size[nb] = blk_size[b] - keep - HEADER_BYTES;
         blk_used[nb] = 0;
         blk_prev[nb] = b;
         blk_size[b] = keep;
         if (next_blk(nb, n)) blk_prev[n] = nb;
      endfunction

      function void merge_with_next(int unsigned b);
         int unsigned nx, n2;
         if (!next_blk(b, nx)) return;
         blk_size[b] += blk_size[nx] + HEADER_BYTES;
         if (next_blk(b, n2)) blk_prev[n2] = b;
         if (cursor_ok && cursor == nx) cursor = b;
      endfunction

      function void allocate(int unsigned size, int unsigned align,
                             output rsp_code_type st, output logic [15:0] off);
         int unsigned a, al, sz, fit, n, nf, base, pad;
         bit found;
         a = (align == 0) ? 1 : align;
         al = ((a + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
         sz = ((size + al - 1) / al) * al;
         off = 0;
         found = 0;
         if (!cursor_ok) begin
            st = ST_NO_FREE;
            return;
         end
         fit = cursor;
         while (!found) begin
            if (!blk_used[fit] && blk_size[fit] >= sz) begin
               base = fit * GRANULE_BYTES;
               if ((base + HEADER_BYTES) % al == 0) begin
                  found = 1;
               end else begin
                  pad = al - ((base + 2 * HEADER_BYTES) % al);
                  if (blk_size[fit] >= pad + HEADER_BYTES + sz) begin
                     split(fit, pad);
                     fit = slot(fit + (HEADER_BYTES + pad) / GRANULE_BYTES);
                     found = 1;
                  end
               end
            end
            if (!found) begin
               if (!next_blk(fit, n)) n = 0;
               fit = n;
               if (fit == cursor) begin
                  st = ST_NO_FIT;
                  return;
               end
            end
         end
         if (blk_size[fit] > sz + HEADER_BYTES) split(fit, sz);
         blk_used[fit] = 1;
         nf = fit;
         do begin
            if (!next_blk(nf, n)) n = 0;
            nf = n;
         end while (nf != fit && blk_used[nf]);
         cursor_ok = (nf != fit);
         cursor = cursor_ok ? nf : 0;
         st = ST_OK;
         off = fit * GRANULE_BYTES + HEADER_BYTES;
         live.push_back(off);
      endfunction

      function void release_blk(int unsigned fo);
         int unsigned t, s, n, p;
         if (fo < HEADER_BYTES) return;
         t = fo - HEADER_BYTES;
         if (t % GRANULE_BYTES != 0 || t >= cap) return;
         s = 0;
         while (s * GRANULE_BYTES < t) begin
            if (!next_blk(s, n)) return;
            s = n;
         end
         if (s * GRANULE_BYTES != t) return;
         foreach (live[i]) if (live[i] == fo) begin
            live.delete(i);
            break;
         end
         blk_used[s] = 0;
         if (!cursor_ok) begin
            cursor = s;
            cursor_ok = 1;
         end
         if (next_blk(s, n) && !blk_used[n]) merge_with_next(s);
         if (s != 0) begin
            p = slot(blk_prev[s]);
            if (!blk_used[p]) merge_with_next(p);
         end
      endfunction

      function void note_request(req_kind_type kind, logic [15:0] size,
                                 logic [12:0] align, logic [15:0] fo);
         rsp_code_type st;
         logic [15:0] off;
         st = ST_OK;
         off = 0;
         case (kind)
            REQ_ALLOC: allocate(size, align, st, off);
            REQ_FREE:  release_blk(fo);
            REQ_FLUSH: reform();
            default: ;
         endcase
         want_status.push_back(st);
         want_offset.push_back(off);
      endfunction

      function void check_result(logic [1:0] st, logic [15:0] off);
         rsp_code_type ws;
         logic [15:0] wo;
         if (want_status.size() == 0) begin
            $error("unexpected result: status %0d data_offset %0d", st, off);
            errors++;
            return;
         end
         ws = want_status.pop_front();
         wo = want_offset.pop_front();
         checked++;
         case (ws)
            ST_OK:      n_ok++;
            ST_NO_FREE: n_no_free++;
            default:    n_no_fit++;
         endcase
         if (st !== ws) begin
            $error("status: expected %0d, actual %0d", ws, st);
            errors++;
         end
         if (off !== wo) begin
            $error("data_offset: expected %0d, actual %0d", wo, off);
            errors++;
         end
      endfunction

      function int pending();
         return want_status.size();
      endfunction
   endclass

   localparam int STALL_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_type = 0;
   logic [15:0] req_size = 0;
   logic [12:0] req_alignment = 0;
   logic [15:0] req_free_offset = 0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_data_offset;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [16:0] csr_heap_bytes = 0;

   heap_scoreboard heap = new();
   int stall_cycles = 0;
   int idle_pct = 35;
   int sent = 0;

   next_fit_heap_allocator_core uut (.*);

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) heap.check_result(rsp_status, rsp_data_offset);
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send(req_kind_type kind, logic [15:0] size, logic [12:0] align,
                       logic [15:0] fo);
      if ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      start = 1;
      req_type = kind;
      req_size = size;
      req_alignment = align;
      req_free_offset = fo;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      heap.note_request(kind, size, align, fo);
      sent++;
   endtask

   // hold off new requests until every result is back
   task automatic drain();
      @(negedge clock);
      start = 0;
      while (heap.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_heap(logic [16:0] v);
      drain();
      @(negedge clock);
      csr_valid = 1;
      csr_heap_bytes = v;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      heap.configure(v);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic random_request();
      int pick;
      logic [15:0] size, fo;
      logic [12:0] align;
      pick = $urandom_range(99);
      size = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      align = ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 64));
      fo = 16'($urandom);
      if (heap.live.size() > 0 && $urandom_range(9) != 0)
         fo = heap.live[$urandom_range(heap.live.size() - 1)];
      if (heap.live.size() > 40 && pick < 60) pick = 60;
      if (pick < 55)      send(REQ_ALLOC, size, align, fo);
      else if (pick < 95) send(REQ_FREE, size, align, fo);
      else if (pick < 98) send(REQ_FLUSH, size, align, fo);
      else                send(REQ_NOP, size, align, fo);
   endtask

   initial begin
      logic [16:0] sizes[6];
      sizes = '{17'd1000, 17'd65536, 17'd4096, 17'd777, 17'd16384, 17'd65536};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // smallest heap: one zero-size alloc fits, then no free block remains
      write_heap(17'd48);
      send(REQ_ALLOC, 16'd0, 13'd0, 16'd0);
      send(REQ_ALLOC, 16'd0, 13'd1, 16'd0);
      send(REQ_FREE, 16'd0, 13'd1, 16'd32);
      send(REQ_FREE, 16'd0, 13'd1, 16'd32);
      send(REQ_ALLOC, 16'd16, 13'd16, 16'd0);
      send(REQ_NOP, 16'hFFFF, 13'h1FFF, 16'hFFFF);
      write_heap(17'd0);
      send(REQ_ALLOC, 16'd17, 13'd1, 16'd0);
      write_heap(17'h1FFFF);
      send(REQ_ALLOC, 16'hFFFF, 13'd4096, 16'd0);
      send(REQ_ALLOC, 16'd16, 13'd4096, 16'd0);
      send(REQ_ALLOC, 16'd100, 13'h1FFF, 16'd0);
      send(REQ_ALLOC, 16'd0, 13'd0, 16'd0);
      send(REQ_FREE, 16'd0, 13'd0, 16'd0);
      send(REQ_FREE, 16'd0, 13'd0, 16'd33);
      send(REQ_FREE, 16'd0, 13'd0, 16'hFFFF);
      send(REQ_FREE, 16'd0, 13'd0, 16'd32);
      send(REQ_FLUSH, 16'd0, 13'd0, 16'd0);
      send(REQ_ALLOC, 16'hFFE0, 13'd16, 16'd0);
      send(REQ_ALLOC, 16'd0, 13'd16, 16'd0);
      send(REQ_FLUSH, 16'd0, 13'd0, 16'd0);

      foreach (sizes[p]) begin
         write_heap((p == 3) ? 17'($urandom_range(48, 65536)) : sizes[p]);
         for (int i = 0; i < 155; i++) begin
            idle_pct = (p == 2) ? 0 : 35;
            if (p == 4 && i == 70) drain();
            random_request();
         end
      end

      drain();
      repeat (200) @(posedge clock);
      $display("ran %0d requests: %0d ok, %0d no free block, %0d no fit",
               sent, heap.n_ok, heap.n_no_free, heap.n_no_fit);
      $display("heap sizes from the clamped minimum to full capacity were used");
      if (heap.errors == 0 && heap.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/nfha_pkg.sv
rtl/nfha_rem_unit.sv
rtl/nfha_datapath.sv
rtl/nfha_ctrl.sv
rtl/next_fit_heap_allocator_core.sv
tb/sv/tb_top.sv
